@@ src/sh4ieu_pkg.sv @@
// ----------------------------------------------------------------------------
// SH-4 integer execute unit package
// Operation codes and field widths shared by the execute unit.
// ----------------------------------------------------------------------------
package sh4ieu_pkg;

  localparam int unsigned OpW = 6;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned ImmW = 12;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 168;

  localparam logic [OpW-1:0] OP_ADD     = 6'd0;
  localparam logic [OpW-1:0] OP_ADDI    = 6'd1;
  localparam logic [OpW-1:0] OP_ADDC    = 6'd2;
  localparam logic [OpW-1:0] OP_ADDV    = 6'd3;
  localparam logic [OpW-1:0] OP_AND     = 6'd4;
  localparam logic [OpW-1:0] OP_ANDI    = 6'd5;
  localparam logic [OpW-1:0] OP_BF      = 6'd6;
  localparam logic [OpW-1:0] OP_BFS     = 6'd7;
  localparam logic [OpW-1:0] OP_BRA     = 6'd8;
  localparam logic [OpW-1:0] OP_BRAF    = 6'd9;
  localparam logic [OpW-1:0] OP_BT      = 6'd10;
  localparam logic [OpW-1:0] OP_BTS     = 6'd11;
  localparam logic [OpW-1:0] OP_CLRMAC  = 6'd12;
  localparam logic [OpW-1:0] OP_CLRS    = 6'd13;
  localparam logic [OpW-1:0] OP_CLRT    = 6'd14;
  localparam logic [OpW-1:0] OP_CMPEQ   = 6'd15;
  localparam logic [OpW-1:0] OP_CMPGE   = 6'd16;
  localparam logic [OpW-1:0] OP_CMPGT   = 6'd17;
  localparam logic [OpW-1:0] OP_CMPHI   = 6'd18;
  localparam logic [OpW-1:0] OP_CMPHS   = 6'd19;
  localparam logic [OpW-1:0] OP_CMPEQI  = 6'd20;
  localparam logic [OpW-1:0] OP_CMPPL   = 6'd21;
  localparam logic [OpW-1:0] OP_CMPPZ   = 6'd22;
  localparam logic [OpW-1:0] OP_CMPSTR  = 6'd23;
  localparam logic [OpW-1:0] OP_DIV0S   = 6'd24;
  localparam logic [OpW-1:0] OP_DIV0U   = 6'd25;
  localparam logic [OpW-1:0] OP_DIV1    = 6'd26;
  localparam logic [OpW-1:0] OP_DMULS   = 6'd27;
  localparam logic [OpW-1:0] OP_DMULU   = 6'd28;
  localparam logic [OpW-1:0] OP_DT      = 6'd29;
  localparam logic [OpW-1:0] OP_EXTSB   = 6'd30;
  localparam logic [OpW-1:0] OP_EXTSW   = 6'd31;
  localparam logic [OpW-1:0] OP_EXTUB   = 6'd32;
  localparam logic [OpW-1:0] OP_EXTUW   = 6'd33;
  localparam logic [OpW-1:0] OP_JMP     = 6'd35;
  localparam logic [OpW-1:0] OP_LDCGBR  = 6'd36;
  localparam logic [OpW-1:0] OP_LDCDBR  = 6'd41;
  localparam logic [OpW-1:0] OP_LDCBANK = 6'd42;
  localparam logic [OpW-1:0] OP_LDSMACH = 6'd43;
  localparam logic [OpW-1:0] OP_LDSMACL = 6'd44;
  localparam logic [OpW-1:0] OP_LDSPR   = 6'd45;
  localparam logic [OpW-1:0] OP_MOV     = 6'd47;
  localparam logic [OpW-1:0] OP_MOVI    = 6'd48;

  localparam int unsigned NumCtrl = 7;
  localparam logic [2:0] CTRL_PR = 3'd6;

endpackage

@@ src/sh4_integer_execute_unit_core.sv @@
// ----------------------------------------------------------------------------
// SH-4 integer execute unit
// Executes one decoded register-only SH-4 instruction per transfer.
// ----------------------------------------------------------------------------
// Usage: instructions arrive on the s_axis channel, one per transfer, and one
// result leaves on the m_axis channel for each instruction, in order.
// An accepted instruction is held in an input register; from there the
// ALU, branch unit and the 32x32 multiplier work on it against the
// architectural state, and the result and the new state are written at the
// same edge into the result register. Throughput is one instruction per
// cycle: the input register and the result register advance together
// whenever the result register is empty or being emptied.
// Because each instruction is executed from the state the previous one left,
// the state is updated at the moment of execution, so back-to-back dependent
// instructions need no forwarding.
// When the receiver stalls, the result register holds, the input register
// holds, and s_axis_tready falls once both are occupied.
// Reset clears all registers, the PC, the status bits, the MAC pair and the
// control registers to zero and empties both pipeline registers.
// ----------------------------------------------------------------------------
module sh4_integer_execute_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[5:0], src_reg[9:6], dst_reg[13:10], immediate[25:14], zeros above
  input  logic [sh4ieu_pkg::InDataW-1:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_pc[31:0], t_flag[32], reg_write_valid[33], reg_write_index[37:34],
  // reg_write_value[69:38], delay_slot_valid[70], delay_slot_pc[102:71],
  // mac_high[134:103], mac_low[166:135], zeros above
  output logic [sh4ieu_pkg::OutDataW-1:0] m_axis_tdata
);
  import sh4ieu_pkg::*;

  // Input register.
  logic        in_vld_q;
  logic [25:0] in_q;
  // Result register.
  logic        out_vld_q;
  logic [166:0] out_q;

  logic adv;
  assign adv = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  // Architectural state.
  logic [31:0] gpr_q [16];
  logic [31:0] bank_q [8];
  logic [31:0] ctrl_q [NumCtrl];
  logic [31:0] pc_q, mach_q, macl_q;
  logic        t_q, s_q, q_q, m_q;

  logic [OpW-1:0] op;
  logic [3:0]  mi, ni;
  logic [11:0] imm;
  assign op  = in_q[5:0];
  assign mi  = in_q[9:6];
  assign ni  = in_q[13:10];
  assign imm = in_q[25:14];

  logic [31:0] rm, rn, r0, simm8, simm12, pc2;
  assign rm = gpr_q[mi];
  assign rn = gpr_q[ni];
  assign r0 = gpr_q[0];
  assign simm8  = {{24{imm[7]}}, imm[7:0]};
  assign simm12 = {{20{imm[11]}}, imm};
  assign pc2 = pc_q + 32'd2;

  // Single multiplier; signed result from the unsigned one by correction.
  logic [63:0] prod_u, prod;
  assign prod_u = 64'(rm) * 64'(rn);
  always_comb begin
    prod = prod_u;
    if (op == OP_DMULS) begin
      prod = prod_u - ({64{rm[31]}} & {rn, 32'd0}) - ({64{rn[31]}} & {rm, 32'd0});
    end
  end

  logic [31:0] next, wval, mach_d, macl_d, x;
  logic        wr, slot, t_d, s_d, q_d, m_d, taken, oldq, carry;
  logic [3:0]  widx;
  logic [32:0] sum;
  logic [31:0] y;

  always_comb begin
    next = pc2; wr = 1'b0; widx = ni; wval = '0; slot = 1'b0;
    t_d = t_q; s_d = s_q; q_d = q_q; m_d = m_q;
    mach_d = mach_q; macl_d = macl_q;
    sum = 33'(rn) + 33'(rm) + 33'(t_q);
    x = rn ^ rm;
    y = {rn[30:0], t_q};
    oldq = q_q; taken = 1'b0; carry = 1'b0;
    case (op)
      OP_ADD:  begin wr = 1'b1; wval = rn + rm; end
      OP_ADDI: begin wr = 1'b1; wval = rn + simm8; end
      OP_ADDC: begin wr = 1'b1; wval = sum[31:0]; t_d = sum[32]; end
      OP_ADDV: begin
        wr = 1'b1; wval = rn + rm;
        t_d = ~(rn[31] ^ rm[31]) & (rn[31] ^ wval[31]);
      end
      OP_AND:  begin wr = 1'b1; wval = rn & rm; end
      OP_ANDI: begin wr = 1'b1; widx = 4'd0; wval = r0 & {24'd0, imm[7:0]}; end
      OP_BF, OP_BFS, OP_BT, OP_BTS: begin
        taken = (op == OP_BF || op == OP_BFS) ? !t_q : t_q;
        slot = (op == OP_BFS || op == OP_BTS);
        if (taken) next = pc_q + 32'd4 + {simm8[30:0], 1'b0};
        else if (slot) next = pc_q + 32'd4;
      end
      OP_BRA:  begin slot = 1'b1; next = pc_q + 32'd4 + {simm12[30:0], 1'b0}; end
      OP_BRAF: begin slot = 1'b1; next = pc_q + 32'd4 + rn; end
      OP_CLRMAC: begin mach_d = '0; macl_d = '0; end
      OP_CLRS:  s_d = 1'b0;
      OP_CLRT:  t_d = 1'b0;
      OP_CMPEQ: t_d = (rn == rm);
      OP_CMPGE: t_d = ($signed(rn) >= $signed(rm));
      OP_CMPGT: t_d = ($signed(rn) > $signed(rm));
      OP_CMPHI: t_d = (rn > rm);
      OP_CMPHS: t_d = (rn >= rm);
      OP_CMPEQI: t_d = (r0 == simm8);
      OP_CMPPL: t_d = ($signed(rn) > 0);
      OP_CMPPZ: t_d = !rn[31];
      OP_CMPSTR: t_d = (x[31:24] == 8'd0) || (x[23:16] == 8'd0) ||
                       (x[15:8] == 8'd0) || (x[7:0] == 8'd0);
      OP_DIV0S: begin q_d = rn[31]; m_d = rm[31]; t_d = rn[31] ^ rm[31]; end
      OP_DIV0U: begin q_d = 1'b0; m_d = 1'b0; t_d = 1'b0; end
      OP_DIV1: begin
        if (oldq == m_q) begin
          wval = y - rm; carry = (wval > y);
        end else begin
          wval = y + rm; carry = (wval < y);
        end
        q_d = rn[31] ^ m_q ^ carry;
        t_d = (q_d == m_q);
        wr = 1'b1;
      end
      OP_DMULS, OP_DMULU: begin mach_d = prod[63:32]; macl_d = prod[31:0]; end
      OP_DT:   begin wr = 1'b1; wval = rn - 32'd1; t_d = (wval == 32'd0); end
      OP_EXTSB: begin wr = 1'b1; wval = {{24{rm[7]}}, rm[7:0]}; end
      OP_EXTSW: begin wr = 1'b1; wval = {{16{rm[15]}}, rm[15:0]}; end
      OP_EXTUB: begin wr = 1'b1; wval = {24'd0, rm[7:0]}; end
      OP_EXTUW: begin wr = 1'b1; wval = {16'd0, rm[15:0]}; end
      OP_JMP:  begin slot = 1'b1; next = rn; end
      OP_LDSMACH: mach_d = rm;
      OP_LDSMACL: macl_d = rm;
      OP_MOV:  begin wr = 1'b1; wval = rm; end
      OP_MOVI: begin wr = 1'b1; wval = simm8; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q <= '0; mach_q <= '0; macl_q <= '0;
      t_q <= 1'b0; s_q <= 1'b0; q_q <= 1'b0; m_q <= 1'b0;
      for (int i = 0; i < 16; i++) gpr_q[i] <= '0;
      for (int i = 0; i < 8; i++) bank_q[i] <= '0;
      for (int i = 0; i < NumCtrl; i++) ctrl_q[i] <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) in_vld_q <= 1'b1;
      else if (adv) in_vld_q <= 1'b0;
      if (adv) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (adv) begin
        pc_q <= next; mach_q <= mach_d; macl_q <= macl_d;
        t_q <= t_d; s_q <= s_d; q_q <= q_d; m_q <= m_d;
        if (wr) gpr_q[widx] <= wval;
        if (op >= OP_LDCGBR && op <= OP_LDCDBR) ctrl_q[3'(op - OP_LDCGBR)] <= rm;
        if (op == OP_LDSPR) ctrl_q[CTRL_PR] <= rm;
        if (op == OP_LDCBANK) bank_q[ni[2:0]] <= rm;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata[25:0];
    if (adv) begin
      out_q <= {macl_d, mach_d, slot ? pc2 : 32'd0, slot,
                wr ? wval : 32'd0, wr ? widx : 4'd0, wr, t_d, next};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'd0, out_q};

  // A result is produced only from a held instruction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> in_vld_q) else $error("advance without instruction");
  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(out_q))
    else $error("result changed under stall");
  // Register write flag and index agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q[33]) |-> (out_q[37:34] == 4'd0))
    else $error("index without write");
  // Full pipe with stalled output refuses input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("accepted while full");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// SH-4 integer execute unit testbench
// Streams decoded instructions into the execute unit and checks every result
// against an architectural model of the unit. Directed instructions come
// first, then random mixes; both sides idle at random except in a full-rate run.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sh4ieu_pkg::*;

  // One executed instruction as seen on the result channel.
  typedef struct packed {
    logic [31:0] mac_lo;
    logic [31:0] mac_hi;
    logic [31:0] slot_pc;
    logic        slot_vld;
    logic [31:0] wr_value;
    logic [3:0]  wr_index;
    logic        wr_vld;
    logic        t;
    logic [31:0] pc;
  } exec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  sh4_integer_execute_unit_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Architectural state of the model, kept in step with the unit.
  logic [31:0] gpr [16];
  logic [31:0] bank [8];
  logic [31:0] ctrl [NumCtrl];
  logic [31:0] pc_q, mach_q, macl_q;
  logic        t_q, s_q, q_q, m_q;

  exec_res_t expected_results [$];
  int  error_count = 0;
  bit  rx_idle_en = 1'b1;   // random receiver stalls
  bit  tx_idle_en = 1'b1;   // random sender gaps
  int  rx_hold = 0;         // cycles of forced receiver hold-off

  function automatic logic [31:0] sext8(logic [11:0] v);
    return {{24{v[7]}}, v[7:0]};
  endfunction

  // Signed greater-than on two 32-bit words.
  function automatic logic sgreater(logic [31:0] a, logic [31:0] b);
    return $signed(a) > $signed(b);
  endfunction

  // Executes one instruction on the model state and returns its result.
  function automatic exec_res_t execute_instr(logic [5:0] op, logic [3:0] m,
                                              logic [3:0] n, logic [11:0] imm);
    exec_res_t r;
    logic [31:0] rm, rn, nxt, wval, y, x32;
    logic [3:0]  widx;
    logic        wr, slot, taken, oldq, carry;
    logic [32:0] sum;
    logic [63:0] prod;
    rm = gpr[m];
    rn = gpr[n];
    nxt = pc_q + 32'd2;
    wr = 1'b0;
    widx = n;
    wval = '0;
    slot = 1'b0;
    case (op)
      OP_ADD: begin wr = 1'b1; wval = rn + rm; end
      OP_ADDI: begin wr = 1'b1; wval = rn + sext8(imm); end
      OP_ADDC: begin
        sum = {1'b0, rn} + {1'b0, rm} + 33'(t_q);
        wr = 1'b1; wval = sum[31:0]; t_q = sum[32];
      end
      OP_ADDV: begin
        wr = 1'b1; wval = rn + rm;
        t_q = (rn[31] == rm[31]) && (wval[31] != rn[31]);
      end
      OP_AND: begin wr = 1'b1; wval = rn & rm; end
      OP_ANDI: begin wr = 1'b1; widx = '0; wval = gpr[0] & {24'd0, imm[7:0]}; end
      OP_BF, OP_BFS, OP_BT, OP_BTS: begin
        taken = (op == OP_BF || op == OP_BFS) ? !t_q : t_q;
        slot = (op == OP_BFS || op == OP_BTS);
        if (taken) nxt = pc_q + 32'd4 + (sext8(imm) << 1);
        else nxt = slot ? pc_q + 32'd4 : pc_q + 32'd2;
      end
      OP_BRA: begin
        slot = 1'b1;
        nxt = pc_q + 32'd4 + ({{20{imm[11]}}, imm} << 1);
      end
      OP_BRAF: begin slot = 1'b1; nxt = pc_q + 32'd4 + rn; end
      OP_CLRMAC: begin mach_q = '0; macl_q = '0; end
      OP_CLRS: s_q = 1'b0;
      OP_CLRT: t_q = 1'b0;
      OP_CMPEQ: t_q = (rn == rm);
      OP_CMPGE: t_q = !sgreater(rm, rn);
      OP_CMPGT: t_q = sgreater(rn, rm);
      OP_CMPHI: t_q = (rn > rm);
      OP_CMPHS: t_q = (rn >= rm);
      OP_CMPEQI: t_q = (gpr[0] == sext8(imm));
      OP_CMPPL: t_q = sgreater(rn, '0);
      OP_CMPPZ: t_q = !rn[31];
      OP_CMPSTR: begin
        x32 = rn ^ rm;
        t_q = (x32[31:24] == 0) || (x32[23:16] == 0) ||
              (x32[15:8] == 0) || (x32[7:0] == 0);
      end
      OP_DIV0S: begin q_q = rn[31]; m_q = rm[31]; t_q = q_q ^ m_q; end
      OP_DIV0U: begin q_q = 1'b0; m_q = 1'b0; t_q = 1'b0; end
      OP_DIV1: begin
        oldq = q_q;
        q_q = rn[31];
        y = {rn[30:0], t_q};
        if (oldq == m_q) begin
          wval = y - rm; carry = (wval > y);
        end else begin
          wval = y + rm; carry = (wval < y);
        end
        q_q = q_q ^ m_q ^ carry;
        t_q = (q_q == m_q);
        wr = 1'b1;
      end
      OP_DMULS: begin
        prod = $signed({{32{rm[31]}}, rm}) * $signed({{32{rn[31]}}, rn});
        mach_q = prod[63:32]; macl_q = prod[31:0];
      end
      OP_DMULU: begin
        prod = {32'd0, rm} * {32'd0, rn};
        mach_q = prod[63:32]; macl_q = prod[31:0];
      end
      OP_DT: begin wr = 1'b1; wval = rn - 32'd1; t_q = (wval == 0); end
      OP_EXTSB: begin wr = 1'b1; wval = {{24{rm[7]}}, rm[7:0]}; end
      OP_EXTSW: begin wr = 1'b1; wval = {{16{rm[15]}}, rm[15:0]}; end
      OP_EXTUB: begin wr = 1'b1; wval = {24'd0, rm[7:0]}; end
      OP_EXTUW: begin wr = 1'b1; wval = {16'd0, rm[15:0]}; end
      OP_JMP: begin slot = 1'b1; nxt = rn; end
      OP_LDCBANK: bank[n[2:0]] = rm;
      OP_LDSMACH: mach_q = rm;
      OP_LDSMACL: macl_q = rm;
      OP_LDSPR: ctrl[CTRL_PR] = rm;
      OP_MOV: begin wr = 1'b1; wval = rm; end
      OP_MOVI: begin wr = 1'b1; wval = sext8(imm); end
      default: begin
        // GBR up to DBR are a contiguous block of control register loads.
        if (op >= OP_LDCGBR && op <= OP_LDCDBR) ctrl[3'(op - OP_LDCGBR)] = rm;
      end
    endcase
    if (wr) gpr[widx] = wval;
    r.slot_pc = slot ? pc_q + 32'd2 : '0;
    pc_q = nxt;
    r.pc = nxt;
    r.t = t_q;
    r.wr_vld = wr;
    r.wr_index = wr ? widx : '0;
    r.wr_value = wr ? wval : '0;
    r.slot_vld = slot;
    r.mac_hi = mach_q;
    r.mac_lo = macl_q;
    return r;
  endfunction

  // Offers one instruction and waits for its transfer; the expectation is
  // computed when the transfer is accepted. The valid stays up after the
  // transfer until the next gap or the next instruction replaces it.
  task automatic send_instr(logic [5:0] op, logic [3:0] m, logic [3:0] n,
                            logic [11:0] imm);
    while (tx_idle_en && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, imm, n, m, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(execute_instr(op, m, n, imm));
  endtask

  // Sender stops offering and waits until every expected result has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a counted hold-off when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 28);
      end
    end
  end

  // Result checker.
  initial begin
    exec_res_t got, exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = exec_res_t'(m_axis_tdata[166:0]);
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer %h", got);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.pc !== exp_r.pc) begin
            $error("next_pc exp %h got %h", exp_r.pc, got.pc); error_count++;
          end
          if (got.t !== exp_r.t) begin
            $error("t_flag exp %h got %h", exp_r.t, got.t); error_count++;
          end
          if (got.wr_vld !== exp_r.wr_vld) begin
            $error("reg_write_valid exp %h got %h", exp_r.wr_vld, got.wr_vld);
            error_count++;
          end
          if (got.wr_index !== exp_r.wr_index) begin
            $error("reg_write_index exp %h got %h", exp_r.wr_index, got.wr_index);
            error_count++;
          end
          if (got.wr_value !== exp_r.wr_value) begin
            $error("reg_write_value exp %h got %h", exp_r.wr_value, got.wr_value);
            error_count++;
          end
          if (got.slot_vld !== exp_r.slot_vld) begin
            $error("delay_slot_valid exp %h got %h", exp_r.slot_vld, got.slot_vld);
            error_count++;
          end
          if (got.slot_pc !== exp_r.slot_pc) begin
            $error("delay_slot_pc exp %h got %h", exp_r.slot_pc, got.slot_pc);
            error_count++;
          end
          if (got.mac_hi !== exp_r.mac_hi) begin
            $error("mac_high exp %h got %h", exp_r.mac_hi, got.mac_hi); error_count++;
          end
          if (got.mac_lo !== exp_r.mac_lo) begin
            $error("mac_low exp %h got %h", exp_r.mac_lo, got.mac_lo); error_count++;
          end
        end
      end
    end
  end

  // Directed: load extreme operands, run edge cases, then every opcode once.
  task automatic test_directed();
    send_instr(OP_MOVI, 4'd0, 4'd1, 12'h07F);
    send_instr(OP_MOVI, 4'd0, 4'd2, 12'hF80);    // sign extension of 0x80
    send_instr(OP_MOVI, 4'd0, 4'd3, 12'h0FF);    // all ones
    send_instr(OP_ADDV, 4'd1, 4'd1, 12'd0);
    send_instr(OP_ADDC, 4'd3, 4'd3, 12'd0);      // carry out
    send_instr(OP_DMULS, 4'd2, 4'd3, 12'd0);
    send_instr(OP_DMULU, 4'd3, 4'd3, 12'd0);
    send_instr(OP_CMPSTR, 4'd3, 4'd2, 12'd0);
    send_instr(OP_DIV0S, 4'd2, 4'd1, 12'd0);
    send_instr(OP_DIV1, 4'd1, 4'd3, 12'd0);
    send_instr(OP_DT, 4'd0, 4'd0, 12'd0);        // zero minus one
    send_instr(OP_BTS, 4'd0, 4'd0, 12'h080);     // backward displacement
    send_instr(OP_BFS, 4'd0, 4'd0, 12'hF7F);
    send_instr(OP_BRA, 4'd0, 4'd0, 12'h800);     // most negative 12-bit
    send_instr(OP_BRA, 4'd0, 4'd0, 12'h7FF);
    send_instr(OP_BRAF, 4'd0, 4'd3, 12'd0);
    send_instr(OP_JMP, 4'd0, 4'd2, 12'd0);
    send_instr(OP_LDCBANK, 4'd3, 4'd15, 12'd0);  // only low bits pick the bank
    send_instr(OP_ANDI, 4'd0, 4'd7, 12'hFFF);
    send_instr(OP_CMPEQI, 4'd0, 4'd0, 12'hF80);
    send_instr(6'd63, 4'd15, 4'd15, 12'hFFF);    // unknown opcode is a no-op
    send_instr(OP_CLRMAC, 4'd0, 4'd0, 12'd0);
    for (int op = 0; op < 64; op++)
      send_instr(6'(op), 4'($urandom), 4'($urandom), 12'($urandom));
  endtask

  function automatic logic [5:0] rand_op();
    return ($urandom_range(19) == 0) ? 6'($urandom_range(63, 49))
                                     : 6'($urandom_range(48));
  endfunction

  // Random mix; division runs are issued as DIV0S/DIV0U followed by DIV1s.
  task automatic test_random(int count);
    logic [3:0] d, s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0) begin
        d = 4'($urandom); s = 4'($urandom);
        send_instr($urandom_range(1) ? OP_DIV0S : OP_DIV0U, s, d, 12'd0);
        repeat ($urandom_range(8, 1)) send_instr(OP_DIV1, s, d, 12'd0);
      end else if ($urandom_range(7) == 0) begin
        send_instr(OP_MOVI, 4'd0, 4'($urandom), 12'($urandom));
      end else begin
        send_instr(rand_op(), 4'($urandom), 4'($urandom), 12'($urandom));
      end
    end
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input.
  task automatic test_backpressure();
    rx_hold = 60;
    test_random(40);
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(300);
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) gpr[i] = '0;
    for (int i = 0; i < 8; i++) bank[i] = '0;
    for (int i = 0; i < NumCtrl; i++) ctrl[i] = '0;
    pc_q = '0; mach_q = '0; macl_q = '0;
    t_q = 1'b0; s_q = 1'b0; q_q = 1'b0; m_q = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350);
    wait_drained();           // sender pauses until all results are back
    test_backpressure();
    test_full_rate();
    test_random(400);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ files.f @@
src/sh4ieu_pkg.sv
src/sh4_integer_execute_unit_core.sv
verif/testbench.sv
